/* hw/rtl/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and helpers for the binary to ASCII number converter.
// ----------------------------------------------------------------------------
package bta_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int BUF_LEN_DEF    = 12;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int MIN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 4;

  // Binary coded decimal correction: a digit of five or more gets three added
  // before the shift.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;
  localparam logic [3:0] DEC_RADIX   = 4'd10;

  // ASCII characters used in the text.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  // Conversion selector.
  typedef enum logic [OP_W-1:0] {
    OP_SIGNED   = 2'd0,
    OP_PADDED   = 2'd1,
    OP_UNSIGNED = 2'd2,
    OP_HEX      = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_NORM,
    ST_EMIT
  } state_e;

  // Commands to the shared shift unit.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD_DEC,
    CMD_LOAD_HEX,
    CMD_DABBLE,
    CMD_SHIFT
  } cmd_e;

  // Control bundle from the sequencer to the shift unit.
  typedef struct packed {
    cmd_e cmd;
    logic negate;
  } unit_ctrl_t;

  // Number of decimal digits of the largest unsigned word of the given width.
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  // Uppercase hexadecimal glyph of one digit.
  function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] digit);
    logic [CHAR_W-1:0] wide;
    wide = {4'h0, digit};
    if (digit < DEC_RADIX) begin
      return CH_ZERO + wide;
    end else begin
      return CH_UPPER_A + wide - {4'h0, DEC_RADIX};
    end
  endfunction

endpackage

/* hw/rtl/bta_if.sv */
// ----------------------------------------------------------------------------
// bta_if
// Request channels of the converter: the word to convert and the characters.
// ----------------------------------------------------------------------------

// Conversion request channel.
interface bta_in_if #(
  parameter int VALUE_BITS = bta_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [bta_pkg::OP_W-1:0]     operation;
  logic [VALUE_BITS-1:0]        value;
  logic [bta_pkg::MIN_W-1:0]    min_digits;

  modport source (output valid, output operation, output value, output min_digits,
                  input ready);
  modport sink   (input valid, input operation, input value, input min_digits,
                  output ready);
endinterface

// Character channel, one request per character.
interface bta_out_if;
  logic                         valid;
  logic                         ready;
  logic [bta_pkg::CHAR_W-1:0]   character;
  logic                         is_last;
  logic [bta_pkg::LEN_W-1:0]    length;

  modport source (output valid, output character, output is_last, output length,
                  input ready);
  modport sink   (input valid, input character, input is_last, input length,
                  output ready);
endinterface

/* hw/rtl/bta_shift_unit.sv */
// ----------------------------------------------------------------------------
// bta_shift_unit
// Shared digit register with a shift-add-3 step, a digit shift and loads.
// ----------------------------------------------------------------------------
module bta_shift_unit #(
  parameter int VALUE_BITS = bta_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  bta_pkg::unit_ctrl_t     ctrl_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  output logic [3:0]              top_digit_o
);

  localparam int NDIG = bta_pkg::dec_digits(VALUE_BITS);
  localparam int DW   = 4 * NDIG;

  logic [DW-1:0]         dig_q, dig_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [DW-1:0]         adj;
  logic [VALUE_BITS-1:0] mag;

  // Each decimal digit is corrected on its own before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig_q[4*i +: 4] >= bta_pkg::BCD_ADJ_MIN) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + bta_pkg::BCD_ADJ;
      end else begin
        adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  // Magnitude of a negative word, formed as an unsigned number.
  assign mag = ctrl_i.negate ? (~value_i + VALUE_BITS'(1)) : value_i;

  // Next value of the digit and binary registers.
  always_comb begin
    dig_d = dig_q;
    bin_d = bin_q;
    case (ctrl_i.cmd)
      bta_pkg::CMD_LOAD_DEC: begin
        dig_d = '0;
        bin_d = mag;
      end
      bta_pkg::CMD_LOAD_HEX: begin
        dig_d = DW'(value_i);
      end
      bta_pkg::CMD_DABBLE: begin
        dig_d = {adj[DW-2:0], bin_q[VALUE_BITS-1]};
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      end
      bta_pkg::CMD_SHIFT: begin
        dig_d = {dig_q[DW-5:0], 4'h0};
      end
      default: begin
        dig_d = dig_q;
      end
    endcase
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  assign top_digit_o = dig_q[DW-1 -: 4];

endmodule

/* hw/rtl/bta_ctrl.sv */
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer: runs the conversion, strips leading zeros and emits characters.
// ----------------------------------------------------------------------------
module bta_ctrl #(
  parameter int BUF_LEN    = bta_pkg::BUF_LEN_DEF,
  parameter int VALUE_BITS = bta_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bta_pkg::op_e                op_i,
  input  logic                        value_msb_i,
  input  logic [bta_pkg::MIN_W-1:0]   min_digits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bta_pkg::CHAR_W-1:0]  character_o,
  output logic                        is_last_o,
  output logic [bta_pkg::LEN_W-1:0]   length_o,
  input  logic [3:0]                  top_digit_i,
  output bta_pkg::unit_ctrl_t         unit_ctrl_o
);

  localparam int NDIG = bta_pkg::dec_digits(VALUE_BITS);
  localparam int NMAX = (NDIG > BUF_LEN) ? NDIG : BUF_LEN;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int BCW  = $clog2(VALUE_BITS + 1);

  bta_pkg::state_e state_q, state_d;
  bta_pkg::op_e    op_q, op_d;
  logic            neg_q, neg_d;
  logic            trim_q, trim_d;
  logic [NW-1:0]   min_q, min_d;
  logic [NW-1:0]   cap_q, cap_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   pre_q, pre_d;
  logic [NW-1:0]   len_q, len_d;
  logic [NW-1:0]   k_q, k_d;
  logic [BCW-1:0]  bitcnt_q, bitcnt_d;

  logic            neg_in;
  logic [NW-1:0]   min_clamped;
  logic [NW-1:0]   pad;
  logic [NW-1:0]   pre_n;
  logic            strip;

  // Sign of the incoming word for the two signed conversions.
  assign neg_in = ((op_i == bta_pkg::OP_SIGNED) || (op_i == bta_pkg::OP_PADDED)) &&
                  value_msb_i;

  // Minimum digit count, clamped to two below the buffer length.
  assign min_clamped = (min_digits_i > bta_pkg::MIN_W'(BUF_LEN - 2)) ?
                       NW'(BUF_LEN - 2) : NW'(min_digits_i);

  // Leading zeros go, and so do digits that would overflow the buffer. Once a
  // significant digit has been cut off the top, zeros stay unless they overflow.
  assign strip = ((cnt_q > NW'(1)) && (top_digit_i == 4'h0) && !trim_q) ||
                 (cnt_q > cap_q);

  // Zero padding up to the minimum digit count.
  assign pad = ((op_q == bta_pkg::OP_PADDED) && (min_q > cnt_q)) ? (min_q - cnt_q) : '0;

  assign pre_n = (op_q == bta_pkg::OP_HEX) ? NW'(2) : (NW'(neg_q) + pad);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    neg_q    <= neg_d;
    trim_q   <= trim_d;
    min_q    <= min_d;
    cap_q    <= cap_d;
    cnt_q    <= cnt_d;
    pre_q    <= pre_d;
    len_q    <= len_d;
    k_q      <= k_d;
    bitcnt_q <= bitcnt_d;
  end

  // Next state and unit commands.
  always_comb begin
    state_d            = state_q;
    op_d               = op_q;
    neg_d              = neg_q;
    trim_d             = trim_q;
    min_d              = min_q;
    cap_d              = cap_q;
    cnt_d              = cnt_q;
    pre_d              = pre_q;
    len_d              = len_q;
    k_d                = k_q;
    bitcnt_d           = bitcnt_q;
    unit_ctrl_o.cmd    = bta_pkg::CMD_NONE;
    unit_ctrl_o.negate = neg_in;
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    unique case (state_q)
      bta_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d   = op_i;
          neg_d  = neg_in;
          trim_d = 1'b0;
          min_d  = min_clamped;
          if (op_i == bta_pkg::OP_HEX) begin
            unit_ctrl_o.cmd = bta_pkg::CMD_LOAD_HEX;
            cnt_d           = NW'(NDIG);
            cap_d           = NW'(BUF_LEN - 3);
            state_d         = bta_pkg::ST_NORM;
          end else begin
            unit_ctrl_o.cmd = bta_pkg::CMD_LOAD_DEC;
            bitcnt_d        = BCW'(VALUE_BITS);
            cap_d           = NW'(BUF_LEN - 1) - NW'(neg_in);
            state_d         = bta_pkg::ST_DABBLE;
          end
        end
      end
      bta_pkg::ST_DABBLE: begin
        unit_ctrl_o.cmd = bta_pkg::CMD_DABBLE;
        bitcnt_d        = bitcnt_q - BCW'(1);
        if (bitcnt_q == BCW'(1)) begin
          cnt_d   = NW'(NDIG);
          state_d = bta_pkg::ST_NORM;
        end
      end
      bta_pkg::ST_NORM: begin
        if (strip) begin
          unit_ctrl_o.cmd = bta_pkg::CMD_SHIFT;
          cnt_d           = cnt_q - NW'(1);
          if ((cnt_q > cap_q) && (top_digit_i != 4'h0)) begin
            trim_d = 1'b1;
          end
        end else begin
          pre_d   = pre_n;
          len_d   = pre_n + cnt_q;
          k_d     = '0;
          state_d = bta_pkg::ST_EMIT;
        end
      end
      bta_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (k_q >= pre_q) begin
            unit_ctrl_o.cmd = bta_pkg::CMD_SHIFT;
          end
          k_d = k_q + NW'(1);
          if (is_last_o) begin
            state_d = bta_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bta_pkg::ST_IDLE;
      end
    endcase
  end

  // Character selection: prefix, sign or padding first, then the digits.
  always_comb begin
    if (k_q < pre_q) begin
      if (op_q == bta_pkg::OP_HEX) begin
        character_o = (k_q == '0) ? bta_pkg::CH_ZERO : bta_pkg::CH_X;
      end else if (neg_q && (k_q == '0)) begin
        character_o = bta_pkg::CH_MINUS;
      end else begin
        character_o = bta_pkg::CH_ZERO;
      end
    end else begin
      character_o = bta_pkg::glyph(top_digit_i);
    end
  end

  assign is_last_o = (k_q == (len_q - NW'(1)));
  assign length_o  = len_q[bta_pkg::LEN_W-1:0];

endmodule

/* hw/rtl/binary_to_ascii_number_core.sv */
// Sequence: a decimal request is loaded and runs VALUE_BITS shift-add-3 steps, then
// strips leading digits one at a time (up to NDIG-1) before it sends its characters,
// each held until the receiver takes it; hex requests skip the shift-add-3.
// Throughput: one request at a time; ready stays low until the last character is taken.
// Reset: asynchronous, active low; clears the sequencer to idle, nothing else is kept.
// ----------------------------------------------------------------------------
// binary_to_ascii_number_core
// Converts a word to signed, zero-padded or unsigned decimal, or to hex text
// with a 0x prefix, and sends the characters most significant first.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_core #(
  parameter int BUF_LEN    = bta_pkg::BUF_LEN_DEF,
  parameter int VALUE_BITS = bta_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bta_in_if.sink    in_i,
  bta_out_if.source out_o
);

  bta_pkg::unit_ctrl_t unit_ctrl;
  logic [3:0]          top_digit;

  // Sequencer.
  bta_ctrl #(
    .BUF_LEN    (BUF_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .op_i         (bta_pkg::op_e'(in_i.operation)),
    .value_msb_i  (in_i.value[VALUE_BITS-1]),
    .min_digits_i (in_i.min_digits),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .character_o  (out_o.character),
    .is_last_o    (out_o.is_last),
    .length_o     (out_o.length),
    .top_digit_i  (top_digit),
    .unit_ctrl_o  (unit_ctrl)
  );

  // Shared shift-add-3 and digit shift unit.
  bta_shift_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_shift_unit (
    .clk_i       (clk_i),
    .ctrl_i      (unit_ctrl),
    .value_i     (in_i.value),
    .top_digit_o (top_digit)
  );

  // The block never takes a request while characters are being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("request accepted while characters are pending");

  // After the last character is taken the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.is_last) |=> in_i.ready)
    else $error("not ready after the last character");

  // A character that is not the last is followed by another one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.is_last) |=> out_o.valid)
    else $error("text ended before its last character");

endmodule

/* dv/binary_to_ascii_number_core_tb.sv */
// ----------------------------------------------------------------------------
// binary_to_ascii_number_core_tb
// Self-checking bench for the word to ASCII number converter. A short table
// of directed requests covers the extremes and the padding clamp. Several
// hundred random requests follow, under changing sender and receiver
// pressure. Every character that leaves the block is checked against the typed
// text or the text that a local model of the conversion predicts.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_core_tb;
  import bta_pkg::*;

  localparam int BUF_LEN     = BUF_LEN_DEF;
  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  // One expected character of a converted text.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic [LEN_W-1:0]  length;
  } text_char_t;

  // One directed request; an empty text means the model predicts it.
  typedef struct {
    op_e                   op;
    logic [VALUE_BITS-1:0] word;
    logic [MIN_W-1:0]      min_dig;
    string                 text;
  } directed_row_t;

  localparam int NUM_ROWS = 24;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{OP_SIGNED,   32'h0000_0000, 7'd0,   "0"},
    '{OP_SIGNED,   32'h7FFF_FFFF, 7'd0,   "2147483647"},
    '{OP_SIGNED,   32'h8000_0000, 7'd0,   "-2147483648"},
    '{OP_SIGNED,   32'hFFFF_FFFF, 7'd0,   "-1"},
    '{OP_SIGNED,   32'd7,         7'd127, "7"},
    '{OP_PADDED,   32'h0000_0000, 7'd0,   "0"},
    '{OP_PADDED,   32'h0000_0000, 7'd127, "0000000000"},
    '{OP_PADDED,   32'd5,         7'd3,   "005"},
    '{OP_PADDED,   32'hFFFF_FFFF, 7'd10,  "-0000000001"},
    '{OP_PADDED,   32'h8000_0000, 7'd127, "-2147483648"},
    '{OP_PADDED,   32'd123456,    7'd11,  "0000123456"},
    '{OP_PADDED,   32'hFFFF_FFF6, 7'd4,   "-0010"},
    '{OP_UNSIGNED, 32'h0000_0000, 7'd0,   "0"},
    '{OP_UNSIGNED, 32'hFFFF_FFFF, 7'd0,   "4294967295"},
    '{OP_UNSIGNED, 32'h8000_0000, 7'd127, "2147483648"},
    '{OP_HEX,      32'h0000_0000, 7'd0,   "0x0"},
    '{OP_HEX,      32'hFFFF_FFFF, 7'd0,   "0xFFFFFFFF"},
    '{OP_HEX,      32'h0000_000A, 7'd127, "0xA"},
    '{OP_HEX,      32'h8000_0000, 7'd0,   "0x80000000"},
    '{OP_HEX,      32'h12AB_CDEF, 7'd9,   ""},
    '{OP_SIGNED,   32'd1000000000, 7'd0,  ""},
    '{OP_PADDED,   32'h5555_5555, 7'd64,  ""},
    '{OP_UNSIGNED, 32'd999999999, 7'd42,  ""},
    '{OP_SIGNED,   32'hAAAA_AAAA, 7'd85,  ""}
  };

  logic clk;
  logic rst_n;

  bta_in_if #(.VALUE_BITS(VALUE_BITS)) req_if ();
  bta_out_if                           char_if ();

  binary_to_ascii_number_core #(
    .BUF_LEN   (BUF_LEN),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (char_if)
  );

  text_char_t pending_chars [$];
  text_char_t oldest_char;
  text_char_t seen_char;
  string      req_text;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         error_count;
  int         quiet_cycles;
  bit         hold_req;

  // Free-running clock.
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Queue a text that was typed into the directed table.
  function automatic void queue_text(input string text);
    int n;
    n = text.len();
    for (int k = 0; k < n; k++) begin
      pending_chars.push_back('{text[k], (k == n - 1), n[LEN_W-1:0]});
    end
  endfunction

  // Predict the characters of one conversion and queue them in order.
  function automatic void predict_text(input op_e op, input logic [VALUE_BITS-1:0] word,
                                       input logic [MIN_W-1:0] min_dig);
    logic [CHAR_W-1:0]     rev [BUF_LEN + 72];
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            nib;
    int                    n;
    int                    cap;
    int                    minimum;
    bit                    neg;
    n = 0;
    neg = 1'b0;
    mag = word;
    if (op == OP_HEX) begin
      cap = BUF_LEN - 3;
      do begin
        nib = mag[3:0];
        rev[n] = (nib < 4'd10) ? CH_ZERO + {4'h0, nib} : CH_UPPER_A + {4'h0, nib} - 8'd10;
        n++;
        mag = mag >> 4;
      end while (mag != 0 && n < cap);
      rev[n] = CH_X;
      n++;
      rev[n] = CH_ZERO;
      n++;
    end else begin
      // Negative words convert through their unsigned magnitude.
      if (op != OP_UNSIGNED && mag[VALUE_BITS-1]) begin
        neg = 1'b1;
        mag = -mag;
      end
      cap = BUF_LEN - 1 - (neg ? 1 : 0);
      do begin
        rev[n] = CH_ZERO + CHAR_W'(mag % 10);
        n++;
        mag = mag / 10;
      end while (mag != 0 && n < cap);
      if (op == OP_PADDED) begin
        minimum = (min_dig > BUF_LEN - 2) ? BUF_LEN - 2 : int'(min_dig);
        while (n < cap && n < minimum) begin
          rev[n] = CH_ZERO;
          n++;
        end
      end
      if (neg) begin
        rev[n] = CH_MINUS;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      pending_chars.push_back('{rev[n - 1 - k], (k == n - 1), n[LEN_W-1:0]});
    end
  endfunction

  // Random word biased towards digit-count boundaries and small magnitudes.
  function automatic logic [VALUE_BITS-1:0] pick_word();
    logic [VALUE_BITS-1:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = $urandom_range(0, 99);
      2: begin
        w = 1;
        repeat ($urandom_range(1, 9)) w = w * 10;
        w = w + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) w = -w;
      end
      3: w = -$urandom_range(1, 1000);
      4: w = $urandom_range(0, 1) ? {1'b1, {(VALUE_BITS-1){1'b0}}} + $urandom_range(0, 3)
                                  : {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
      default: w = $urandom >> $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  // Offer one request, with random idle cycles ahead of it.
  task automatic offer_request(input op_e op, input logic [VALUE_BITS-1:0] word,
                               input logic [MIN_W-1:0] min_dig, input string text);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.value      <= word;
    req_if.min_digits <= min_dig;
    req_text          <= text;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Run a block of random requests under the given pressure.
  task automatic random_phase(input int count, input int idle_pct, input int stall_pct,
                              input bit with_hold);
    logic [MIN_W-1:0] md;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // Long receiver hold-off while requests keep coming.
      if (with_hold && i == 5) hold_req <= ~hold_req;
      md = $urandom_range(0, 1) ? MIN_W'($urandom_range(0, 127)) : MIN_W'($urandom_range(0, 12));
      offer_request(op_e'($urandom_range(0, 3)), pick_word(), md, "");
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    char_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        char_if.ready <= 1'b0;
        hold_left--;
      end else begin
        char_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Prediction on accepted requests, checking of accepted characters, watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        if (req_text.len() != 0) begin
          queue_text(req_text);
        end else begin
          predict_text(op_e'(req_if.operation), req_if.value, req_if.min_digits);
        end
      end
      if (char_if.valid && char_if.ready) begin
        seen_char = '{char_if.character, char_if.is_last, char_if.length};
        if (pending_chars.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected character: expected none, actual %h last %b len %0d",
                     $time, seen_char.character, seen_char.is_last, seen_char.length);
          end
        end else begin
          oldest_char = pending_chars.pop_front();
          if (seen_char !== oldest_char) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected %h last %b len %0d, actual %h last %b len %0d",
                       $time, oldest_char.character, oldest_char.is_last, oldest_char.length,
                       seen_char.character, seen_char.is_last, seen_char.length);
            end
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (char_if.valid && char_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("binary_to_ascii_number_core_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // Reset, directed table, random phases and drain.
  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_SIGNED;
    req_if.value      = '0;
    req_if.min_digits = '0;
    req_text          = "";
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    error_count       = 0;
    quiet_cycles      = 0;
    hold_req          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].min_dig,
                    directed_rows[i].text);
    end

    random_phase(90, 0, 0, 1'b1);
    random_phase(90, 69, 0, 1'b0);
    random_phase(90, 0, 69, 1'b0);
    random_phase(80, 28, 28, 1'b0);
    req_if.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("binary_to_ascii_number_core_tb: done, clean");
    end else begin
      $display("binary_to_ascii_number_core_tb: done, errors");
    end
    $finish;
  end

endmodule
